### sv/refined_grid_separation_filter_unit_defines.svh
// Assertion macros used by the refined grid separation filter checker.
`ifndef REFINED_GRID_SEPARATION_FILTER_UNIT_DEFINES_SVH
`define REFINED_GRID_SEPARATION_FILTER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RGSF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RGSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### sv/rgsf_pkg.sv
// Types, constants and the offset snapping function of the separation filter.
package rgsf_pkg;

   localparam int CUBE_W   = 7;
   localparam int SUB_W    = 9;
   localparam int CELLS_W  = 8;
   localparam int SEP_W    = 3;
   localparam int SPLIT_W  = 3;
   localparam int STATUS_W = 2;
   localparam int OFS_W    = 5;
   localparam int FACT_W   = 4;
   localparam int LOC_W    = 3;
   localparam int RX_W     = 11;
   localparam int PROD_W   = 12;
   localparam int NB_W     = 13;
   localparam int DELTA_W  = 4;
   localparam int EPOCH_W  = 4;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_CNT_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_ACCEPT   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DEC_A,
      ST_WAIT_A,
      ST_DEC_B,
      ST_WAIT_B,
      ST_PREP,
      ST_RANGE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic              go;
      logic [SUB_W-1:0]  dividend;
      logic [FACT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [SUB_W-1:0]  quotient;
      logic [LOC_W-1:0]  remainder;
   } div_rsp_type;

   localparam logic [2:0] SET_LEN [4] = '{3'd1, 3'd3, 3'd3, 3'd5};
   localparam logic [OFS_W-1:0] SET_VALS [4][5] = '{
      '{5'd8, 5'd0, 5'd0, 5'd0, 5'd0},
      '{5'd4, 5'd8, 5'd12, 5'd0, 5'd0},
      '{5'd2, 5'd8, 5'd14, 5'd0, 5'd0},
      '{5'd1, 5'd5, 5'd8, 5'd11, 5'd15}
   };

   // Nearest allowed fraction to (2*loc+1)/(2*f), in sixteenths; ties keep the smaller one.
   function automatic logic [OFS_W-1:0] snap_offset(input logic [LOC_W-1:0]   loc,
                                                    input logic [FACT_W-1:0]  f,
                                                    input logic [SPLIT_W-1:0] split);
      logic [1:0]       sel;
      logic [7:0]       num;
      logic [7:0]       t;
      logic [7:0]       d;
      logic [7:0]       best_d;
      logic [OFS_W-1:0] best;
      if (split >= 3'd4) begin
         sel = 2'd3;
      end else if (split >= 3'd2) begin
         sel = 2'd2;
      end else begin
         sel = split[1:0];
      end
      num    = {loc, 1'b1, 4'b0000};
      best_d = 8'hFF;
      best   = '0;
      for (int i = 0; i < 5; i++) begin
         if (3'(i) < SET_LEN[sel]) begin
            t = 8'({4'b0000, f} * {3'b000, SET_VALS[sel][i]}) << 1;
            d = (num > t) ? (num - t) : (t - num);
            if (d < best_d) begin
               best_d = d;
               best   = SET_VALS[sel][i];
            end
         end
      end
      return best;
   endfunction

endpackage

### sv/refined_grid_separation_filter_unit.sv
// The neighborhood scan reads one occupancy word per cycle over a cube of the clamped
// radius around the request; an out-of-range request skips the scan.
// A conflict ends the scan at the first occupied neighbor. The next request is taken
// in the strobe cycle. After reset, and on a new_batch that rolls the batch epoch over,
// a clearing pass writes every map word with busy high.
// Reset is synchronous and sets the configuration and control registers to their defaults.
module refined_grid_separation_filter_unit #(
   parameter int REFINED_AXIS_BITS = 7,
   parameter int MAX_CLEARANCE     = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_new_batch,
   input  logic [rgsf_pkg::CUBE_W-1:0]     req_cube_x,
   input  logic [rgsf_pkg::CUBE_W-1:0]     req_cube_y,
   input  logic [rgsf_pkg::CUBE_W-1:0]     req_cube_z,
   input  logic [rgsf_pkg::SUB_W-1:0]      req_subgrid_index,
   output logic                            rsp_valid,
   output logic [rgsf_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rgsf_pkg::OFS_W-1:0]      rsp_offset_x,
   output logic [rgsf_pkg::OFS_W-1:0]      rsp_offset_y,
   output logic [rgsf_pkg::OFS_W-1:0]      rsp_offset_z,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rgsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rgsf_pkg::CELLS_W-1:0]    csr_data
);
   import rgsf_pkg::*;

   localparam int ADDR_W    = 3 * REFINED_AXIS_BITS;
   localparam int MAP_DEPTH = 1 << ADDR_W;
   localparam logic [RX_W-1:0]   AXIS_R = RX_W'(1 << REFINED_AXIS_BITS);
   localparam logic [PROD_W-1:0] AXIS_P = PROD_W'(1 << REFINED_AXIS_BITS);
   localparam logic [SEP_W-1:0]  CLR_MAX = SEP_W'(MAX_CLEARANCE);

   // Configuration registers.
   logic [CELLS_W-1:0] cells_x_ff, cells_y_ff, cells_z_ff;
   logic [SEP_W-1:0]   sep_ff;
   logic [SPLIT_W-1:0] split_ff;

   // Control state.
   state_type          state_ff, state_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               resume_ff, resume_in;
   logic               rd_pend_ff, rd_pend_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;

   // Request payload and derived values.
   logic [CUBE_W-1:0]  cube_x_ff, cube_y_ff, cube_z_ff;
   logic [SUB_W-1:0]   sub_ff;
   logic [SUB_W-1:0]   q1_ff, q1_in;
   logic [LOC_W-1:0]   lx_ff, lx_in, ly_ff, ly_in;
   logic [SUB_W-1:0]   lz_ff, lz_in;
   logic [RX_W-1:0]    rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic [PROD_W-1:0]  bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic [SEP_W-1:0]   rad_ff, rad_in;
   logic               bad_ff, bad_in;

   // Result registers.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OFS_W-1:0]    ofs_x_ff, ofs_x_in, ofs_y_ff, ofs_y_in, ofs_z_ff, ofs_z_in;

   logic               accept;
   logic [FACT_W-1:0]  fact;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [EPOCH_W-1:0] mem_wdata, mem_rdata;
   logic signed [NB_W-1:0] nx, ny, nz;
   logic               nb_ok, is_self, last, hit;
   logic signed [DELTA_W-1:0] rad_s;
   logic [PROD_W-1:0]  px, py, pz;
   logic [SEP_W-1:0]   rad_raw;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign fact      = {1'b0, split_ff} + FACT_W'(1);
   assign rad_s     = $signed({1'b0, rad_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= CELLS_W'(2);
         cells_y_ff <= CELLS_W'(2);
         cells_z_ff <= CELLS_W'(2);
         sep_ff     <= SEP_W'(1);
         split_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CELLS_X: cells_x_ff <= csr_data;
            CSR_CELLS_Y: cells_y_ff <= csr_data;
            CSR_CELLS_Z: cells_z_ff <= csr_data;
            CSR_SEP:     sep_ff     <= csr_data[SEP_W-1:0];
            CSR_SPLIT:   split_ff   <= csr_data[SPLIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rgsf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Each word holds the epoch of the batch that marked it; zero never matches.
   rgsf_ram #(
      .WIDTH (EPOCH_W),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Neighbor coordinates for the current scan offset.
   assign nx = $signed({2'b00, rx_ff}) + NB_W'(dx_ff);
   assign ny = $signed({2'b00, ry_ff}) + NB_W'(dy_ff);
   assign nz = $signed({2'b00, rz_ff}) + NB_W'(dz_ff);
   assign is_self = (dx_ff == '0) && (dy_ff == '0) && (dz_ff == '0);
   assign nb_ok = !is_self
      && !nx[NB_W-1] && (nx[PROD_W-1:0] < bx_ff)
      && !ny[NB_W-1] && (ny[PROD_W-1:0] < by_ff)
      && !nz[NB_W-1] && (nz[PROD_W-1:0] < bz_ff);
   assign last = (dx_ff == rad_s) && (dy_ff == rad_s) && (dz_ff == rad_s);
   assign hit  = rd_pend_ff && (mem_rdata == epoch_ff);
   assign mem_raddr = {nz[REFINED_AXIS_BITS-1:0], ny[REFINED_AXIS_BITS-1:0],
                       nx[REFINED_AXIS_BITS-1:0]};

   assign rad_raw = (sep_ff != '0) ? (sep_ff - SEP_W'(1)) : '0;
   assign px = PROD_W'(fact) * PROD_W'(cells_x_ff - CELLS_W'(1));
   assign py = PROD_W'(fact) * PROD_W'(cells_y_ff - CELLS_W'(1));
   assign pz = PROD_W'(fact) * PROD_W'(cells_z_ff - CELLS_W'(1));

   always_comb begin
      state_in      = state_ff;
      epoch_in      = epoch_ff;
      clr_addr_in   = clr_addr_ff;
      resume_in     = resume_ff;
      rd_pend_in    = 1'b0;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dz_in         = dz_ff;
      q1_in         = q1_ff;
      lx_in         = lx_ff;
      ly_in         = ly_ff;
      lz_in         = lz_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rz_in         = rz_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      bz_in         = bz_ff;
      rad_in        = rad_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      ofs_x_in      = ofs_x_ff;
      ofs_y_in      = ofs_y_ff;
      ofs_z_in      = ofs_z_ff;
      div_req       = '0;
      mem_we        = 1'b0;
      mem_waddr     = clr_addr_ff;
      mem_wdata     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               resume_in = 1'b0;
               state_in  = resume_ff ? ST_DEC_A : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DEC_A;
               if (req_new_batch) begin
                  if (epoch_ff == '1) begin
                     // Epoch rolls over: old marks could alias, so wipe the map first.
                     epoch_in    = EPOCH_W'(1);
                     clr_addr_in = '0;
                     resume_in   = 1'b1;
                     state_in    = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         ST_DEC_A: begin
            div_req.go       = 1'b1;
            div_req.dividend = sub_ff;
            div_req.divisor  = fact;
            state_in         = ST_WAIT_A;
         end
         ST_WAIT_A: begin
            if (div_rsp.done) begin
               lx_in    = div_rsp.remainder;
               q1_in    = div_rsp.quotient;
               state_in = ST_DEC_B;
            end
         end
         ST_DEC_B: begin
            div_req.go       = 1'b1;
            div_req.dividend = q1_ff;
            div_req.divisor  = fact;
            state_in         = ST_WAIT_B;
         end
         ST_WAIT_B: begin
            if (div_rsp.done) begin
               ly_in    = div_rsp.remainder;
               lz_in    = div_rsp.quotient;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rx_in  = RX_W'(fact) * RX_W'(cube_x_ff) + RX_W'(lx_ff);
            ry_in  = RX_W'(fact) * RX_W'(cube_y_ff) + RX_W'(ly_ff);
            rz_in  = RX_W'(fact) * RX_W'(cube_z_ff) + RX_W'(lz_ff[LOC_W-1:0]);
            bx_in  = (px > AXIS_P) ? AXIS_P : px;
            by_in  = (py > AXIS_P) ? AXIS_P : py;
            bz_in  = (pz > AXIS_P) ? AXIS_P : pz;
            rad_in = (rad_raw > CLR_MAX) ? CLR_MAX : rad_raw;
            // A quotient of f or more means the index is past the last subcell.
            bad_in = (lz_ff >= SUB_W'(fact))
               || (cells_x_ff < CELLS_W'(2)) || ({1'b0, cube_x_ff} >= cells_x_ff - 1'b1)
               || (cells_y_ff < CELLS_W'(2)) || ({1'b0, cube_y_ff} >= cells_y_ff - 1'b1)
               || (cells_z_ff < CELLS_W'(2)) || ({1'b0, cube_z_ff} >= cells_z_ff - 1'b1);
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (bad_ff || (rx_ff >= AXIS_R) || (ry_ff >= AXIS_R) || (rz_ff >= AXIS_R)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_RANGE;
               ofs_x_in      = '0;
               ofs_y_in      = '0;
               ofs_z_in      = '0;
               state_in      = ST_IDLE;
            end else begin
               dx_in    = -rad_s;
               dy_in    = -rad_s;
               dz_in    = -rad_s;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_CONFLICT;
               ofs_x_in      = '0;
               ofs_y_in      = '0;
               ofs_z_in      = '0;
               state_in      = ST_IDLE;
            end else begin
               rd_pend_in = nb_ok;
               if (dx_ff != rad_s) begin
                  dx_in = dx_ff + 1'b1;
               end else begin
                  dx_in = -rad_s;
                  if (dy_ff != rad_s) begin
                     dy_in = dy_ff + 1'b1;
                  end else begin
                     dy_in = -rad_s;
                     dz_in = dz_ff + 1'b1;
                  end
               end
               if (last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (hit) begin
               rsp_status_in = STATUS_CONFLICT;
               ofs_x_in      = '0;
               ofs_y_in      = '0;
               ofs_z_in      = '0;
            end else begin
               mem_we        = 1'b1;
               mem_waddr     = {rz_ff[REFINED_AXIS_BITS-1:0], ry_ff[REFINED_AXIS_BITS-1:0],
                                rx_ff[REFINED_AXIS_BITS-1:0]};
               mem_wdata     = epoch_ff;
               rsp_status_in = STATUS_ACCEPT;
               ofs_x_in      = snap_offset(lx_ff, fact, split_ff);
               ofs_y_in      = snap_offset(ly_ff, fact, split_ff);
               ofs_z_in      = snap_offset(lz_ff[LOC_W-1:0], fact, split_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         epoch_ff     <= EPOCH_W'(1);
         clr_addr_ff  <= '0;
         resume_ff    <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         epoch_ff     <= epoch_in;
         clr_addr_ff  <= clr_addr_in;
         resume_ff    <= resume_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         cube_x_ff <= req_cube_x;
         cube_y_ff <= req_cube_y;
         cube_z_ff <= req_cube_z;
         sub_ff    <= req_subgrid_index;
      end
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      dz_ff         <= dz_in;
      q1_ff         <= q1_in;
      lx_ff         <= lx_in;
      ly_ff         <= ly_in;
      lz_ff         <= lz_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      rz_ff         <= rz_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      bz_ff         <= bz_in;
      rad_ff        <= rad_in;
      bad_ff        <= bad_in;
      rsp_status_ff <= rsp_status_in;
      ofs_x_ff      <= ofs_x_in;
      ofs_y_ff      <= ofs_y_in;
      ofs_z_ff      <= ofs_z_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_offset_x = ofs_x_ff;
   assign rsp_offset_y = ofs_y_ff;
   assign rsp_offset_z = ofs_z_ff;

endmodule

### sv/rgsf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module rgsf_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/rgsf_div.sv
// Bit-serial restoring divider that splits the subgrid index by the refinement factor.
module rgsf_div (
   input  logic                      clock,
   input  logic                      reset,
   input  rgsf_pkg::div_req_type     req,
   output rgsf_pkg::div_rsp_type     rsp
);
   import rgsf_pkg::*;

   logic [SUB_W-1:0]     quo_ff, quo_in;
   logic [LOC_W-1:0]     rem_ff, rem_in;
   logic [FACT_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [LOC_W:0]       trial;
   logic                 fits;

   // Shift the next dividend bit into the partial remainder.
   assign trial = {rem_ff, quo_ff[SUB_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.go) begin
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
         cnt_in = DIV_CNT_W'(SUB_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? LOC_W'(trial - {1'b0, dvs_ff}) : trial[LOC_W-1:0];
         quo_in = {quo_ff[SUB_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

### sv/rgsf_checker.sv
// Port-level checker for the separation filter and its bind to the top level.
`include "refined_grid_separation_filter_unit_defines.svh"

module rgsf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [rgsf_pkg::STATUS_W-1:0]  rsp_status,
   input logic [rgsf_pkg::OFS_W-1:0]     rsp_offset_x,
   input logic [rgsf_pkg::OFS_W-1:0]     rsp_offset_y,
   input logic [rgsf_pkg::OFS_W-1:0]     rsp_offset_z
);
   import rgsf_pkg::*;

   // A taken request keeps the block busy until its result is out.
   `RGSF_ASSERT_NEXT(a_busy_after_request, clock, reset, start && !busy, busy)
   // The result strobe comes as the block goes idle, never while it still works.
   `RGSF_ASSERT_SAME(a_strobe_when_idle, clock, reset, rsp_valid, !busy)
   // Each request yields a single one-cycle strobe.
   `RGSF_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   // Offsets are zero on every result that is not an acceptance.
   `RGSF_ASSERT_SAME(a_zero_offsets, clock, reset,
      rsp_valid && (rsp_status != STATUS_ACCEPT),
      (rsp_offset_x == '0) && (rsp_offset_y == '0) && (rsp_offset_z == '0))

endmodule

bind refined_grid_separation_filter_unit rgsf_checker u_rgsf_checker (.*);
